### hw/rtl/bfp_pkg.sv
`timescale 1ns / 1ps

package bfp_pkg;

  localparam int NUM_BUFS  = 16;
  localparam int NUM_DIMS  = 4;
  localparam int DIM_BITS  = 15;
  localparam int MAX_DIMS  = 4;
  localparam int KIND_BITS = 4;
  localparam int ID_BITS   = 4;
  localparam int STAT_BITS = 3;

  localparam int IDX_BITS   = $clog2(NUM_BUFS);
  localparam int STAMP_BITS = IDX_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BUFS + 1);
  localparam int PAIR_BITS  = 2 * DIM_BITS;
  localparam int AREA_BITS  = 2 * PAIR_BITS;
  localparam int SUM_BITS   = DIM_BITS + 3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STAT_BITS-1:0] {
    ST_FIT        = 3'd0,
    ST_EXPAND     = 3'd1,
    ST_NEW        = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_FULL       = 3'd4,
    ST_NOT_IN_USE = 3'd5
  } status_t;

  typedef logic [NUM_DIMS-1:0][DIM_BITS-1:0] dims_t;

  typedef enum logic [2:0] {
    PC_NONE,
    PC_RELEASE,
    PC_TAKE,
    PC_EXPAND,
    PC_CREATE
  } pool_op_t;

  typedef struct packed {
    pool_op_t               op;
    logic [IDX_BITS-1:0]    idx;
    logic [KIND_BITS-1:0]   mem_kind;
    logic [KIND_BITS-1:0]   data_kind;
    dims_t                  dims;
  } pool_cmd_t;

  typedef struct packed {
    logic                   valid;
    logic                   busy;
    logic [KIND_BITS-1:0]   mem_kind;
    logic [KIND_BITS-1:0]   data_kind;
    dims_t                  dims;
    logic [STAMP_BITS-1:0]  stamp;
  } entry_rd_t;

  // Dimension k of a shape, or one where the shape has fewer dimensions.
  function automatic logic [DIM_BITS-1:0] pad_dim(dims_t v, int k);
    logic [DIM_BITS-1:0] r;
    r = DIM_BITS'(1);
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (d == k) r = v[d];
    end
    return r;
  endfunction

  // Reject a shape whose per-dimension differences change direction
  // against the running sum of differences.
  function automatic logic shape_ok(dims_t have, dims_t want);
    logic signed [DIM_BITS:0]   diff;
    logic signed [SUM_BITS-1:0] sum;
    logic                       ok;
    sum = '0;
    ok  = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      diff = $signed({1'b0, have[d]}) - $signed({1'b0, want[d]});
      if ((diff >= 0 && sum < 0) || (diff <= 0 && sum > 0)) ok = 1'b0;
      sum = sum + SUM_BITS'(diff);
    end
    return ok;
  endfunction

endpackage

### hw/rtl/best_fit_buffer_pool_core.sv
`timescale 1ns / 1ps

// Channel   Beat signals                                        Direction
// in        in_valid in_ready op mem_kind data_kind dim_0..3    in
//           release_id
// out       out_valid out_ready buffer_id status                out
// cfg       cfg_valid cfg_ready cfg_data (strict_shape_mode)    in
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Release: the sequencer goes from idle straight to its decision step. Allocate: the request
// area is formed first, then each entry is checked in turn, and a candidate entry takes 3 passes
// through the shared 30x30 multiplier, a difference and a compare; the decision step follows
// the last entry. The result register lets the next item be accepted while
// a result waits; a stalled out channel holds the sequencer at its final step.
// Reset clears the entry flags, the free count and the mode register.

module best_fit_buffer_pool_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [bfp_pkg::KIND_BITS-1:0] mem_kind,
  input  logic [bfp_pkg::KIND_BITS-1:0] data_kind,
  input  logic [bfp_pkg::DIM_BITS-1:0]  dim_0,
  input  logic [bfp_pkg::DIM_BITS-1:0]  dim_1,
  input  logic [bfp_pkg::DIM_BITS-1:0]  dim_2,
  input  logic [bfp_pkg::DIM_BITS-1:0]  dim_3,
  input  logic [bfp_pkg::ID_BITS-1:0]   release_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfp_pkg::ID_BITS-1:0]   buffer_id,
  output logic [bfp_pkg::STAT_BITS-1:0] status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);
  import bfp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_W0, S_W1, S_W2, S_WCAP, S_CHECK,
    S_E0, S_E1, S_E2, S_DIFF, S_CMP, S_DECIDE
  } state_t;

  state_t                state;
  logic                  strict_mode;
  logic                  op_q;
  logic [ID_BITS-1:0]    rid;
  logic                  rid_ok;
  logic [IDX_BITS-1:0]   idx;
  logic [KIND_BITS-1:0]  mk;
  logic [KIND_BITS-1:0]  dk;
  dims_t                 want;
  logic [AREA_BITS-1:0]  want_area;
  logic [PAIR_BITS-1:0]  pair_lo;
  logic                  dist_ge;
  logic [AREA_BITS-1:0]  dist_mag;
  logic                  fit_found;
  logic [IDX_BITS-1:0]   fit_idx;
  logic [AREA_BITS-1:0]  fit_mag;
  logic [STAMP_BITS-1:0] fit_stamp;
  logic                  lack_found;
  logic [IDX_BITS-1:0]   lack_idx;
  logic [AREA_BITS-1:0]  lack_mag;
  logic [STAMP_BITS-1:0] lack_stamp;
  logic                  have_slot;
  logic [IDX_BITS-1:0]   slot_idx;
  logic [ID_BITS-1:0]    out_id;
  status_t               out_status;
  logic                  out_valid_q;

  logic                          mul_en;
  logic [PAIR_BITS-1:0]          mul_a;
  logic [PAIR_BITS-1:0]          mul_b;
  logic [AREA_BITS-1:0]          mul_p;
  entry_rd_t                     rd;
  pool_cmd_t                     cmd;
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] raw_dims;
  dims_t                         in_dims;
  logic                          last;
  logic                          eligible;
  logic                          can_out;
  logic                          fit_better;
  logic                          lack_better;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_q;
  assign buffer_id = out_id;
  assign status    = out_status;

  assign raw_dims = {dim_3, dim_2, dim_1, dim_0};
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) in_dims[d] = raw_dims[d];
  end

  assign last    = (idx == IDX_BITS'(NUM_BUFS - 1));
  assign can_out = !out_valid_q || out_ready;

  assign eligible = rd.valid && !rd.busy && rd.mem_kind == mk && rd.data_kind == dk &&
                    (!strict_mode || shape_ok(rd.dims, want));

  assign fit_better  = !fit_found || dist_mag < fit_mag ||
                       (dist_mag == fit_mag && rd.stamp < fit_stamp);
  assign lack_better = !lack_found || dist_mag < lack_mag ||
                       (dist_mag == lack_mag && rd.stamp < lack_stamp);

  // operand steering for the shared multiplier: two pair products, then
  // the product of the pairs
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_W0: begin
        mul_en = 1'b1;
        mul_a  = PAIR_BITS'(pad_dim(want, 0));
        mul_b  = PAIR_BITS'(pad_dim(want, 1));
      end
      S_W1: begin
        mul_en = 1'b1;
        mul_a  = PAIR_BITS'(pad_dim(want, 2));
        mul_b  = PAIR_BITS'(pad_dim(want, 3));
      end
      S_E0: begin
        mul_en = 1'b1;
        mul_a  = PAIR_BITS'(pad_dim(rd.dims, 0));
        mul_b  = PAIR_BITS'(pad_dim(rd.dims, 1));
      end
      S_E1: begin
        mul_en = 1'b1;
        mul_a  = PAIR_BITS'(pad_dim(rd.dims, 2));
        mul_b  = PAIR_BITS'(pad_dim(rd.dims, 3));
      end
      S_W2, S_E2: begin
        mul_en = 1'b1;
        mul_a  = pair_lo;
        mul_b  = mul_p[PAIR_BITS-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.op        = PC_NONE;
    cmd.idx       = idx;
    cmd.mem_kind  = mk;
    cmd.data_kind = dk;
    cmd.dims      = want;
    if (state == S_DECIDE && can_out) begin
      if (op_q == OP_RELEASE) begin
        if (rid_ok && rd.valid && rd.busy) cmd.op = PC_RELEASE;
      end else if (fit_found) begin
        cmd.op  = PC_TAKE;
        cmd.idx = fit_idx;
      end else if (lack_found) begin
        cmd.op  = PC_EXPAND;
        cmd.idx = lack_idx;
      end else if (have_slot) begin
        cmd.op  = PC_CREATE;
        cmd.idx = slot_idx;
      end
    end
  end

  bfp_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  bfp_pool u_pool (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (idx),
    .rd     (rd),
    .cmd    (cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strict_mode <= 1'b0;
      out_valid_q <= 1'b0;
      fit_found   <= 1'b0;
      lack_found  <= 1'b0;
      have_slot   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) strict_mode <= cfg_data;
      if (out_valid_q && out_ready && state != S_DECIDE) out_valid_q <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            mk         <= mem_kind;
            dk         <= data_kind;
            want       <= in_dims;
            rid        <= release_id;
            rid_ok     <= int'(release_id) < NUM_BUFS;
            fit_found  <= 1'b0;
            lack_found <= 1'b0;
            have_slot  <= 1'b0;
            if (op == OP_RELEASE) begin
              idx   <= IDX_BITS'(release_id);
              state <= S_DECIDE;
            end else begin
              idx   <= '0;
              state <= S_W0;
            end
          end
        end
        S_W0: state <= S_W1;
        S_W1: begin
          pair_lo <= mul_p[PAIR_BITS-1:0];
          state   <= S_W2;
        end
        S_W2: state <= S_WCAP;
        S_WCAP: begin
          want_area <= mul_p;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          // remember the lowest unused slot in case nothing matches
          if (!rd.valid && !have_slot) begin
            have_slot <= 1'b1;
            slot_idx  <= idx;
          end
          if (eligible) begin
            state <= S_E0;
          end else if (last) begin
            state <= S_DECIDE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_E0: state <= S_E1;
        S_E1: begin
          pair_lo <= mul_p[PAIR_BITS-1:0];
          state   <= S_E2;
        end
        S_E2: state <= S_DIFF;
        S_DIFF: begin
          dist_ge  <= mul_p >= want_area;
          dist_mag <= (mul_p >= want_area) ? mul_p - want_area : want_area - mul_p;
          state    <= S_CMP;
        end
        S_CMP: begin
          if (dist_ge) begin
            if (fit_better) begin
              fit_found <= 1'b1;
              fit_idx   <= idx;
              fit_mag   <= dist_mag;
              fit_stamp <= rd.stamp;
            end
          end else if (lack_better) begin
            lack_found <= 1'b1;
            lack_idx   <= idx;
            lack_mag   <= dist_mag;
            lack_stamp <= rd.stamp;
          end
          if (last) begin
            state <= S_DECIDE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CHECK;
          end
        end
        S_DECIDE: begin
          // hold until the result register is free
          if (can_out) begin
            out_valid_q <= 1'b1;
            state       <= S_IDLE;
            if (op_q == OP_RELEASE) begin
              out_id     <= rid;
              out_status <= (rid_ok && rd.valid && rd.busy) ? ST_RELEASED : ST_NOT_IN_USE;
            end else if (fit_found) begin
              out_id     <= ID_BITS'(fit_idx);
              out_status <= ST_FIT;
            end else if (lack_found) begin
              out_id     <= ID_BITS'(lack_idx);
              out_status <= ST_EXPAND;
            end else if (have_slot) begin
              out_id     <= ID_BITS'(slot_idx);
              out_status <= ST_NEW;
            end else begin
              out_id     <= '0;
              out_status <= ST_FULL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(state == S_DECIDE))
    else $error("result beat not produced by the decision step");

  a_cmp_on_free: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> rd.valid && !rd.busy)
    else $error("compare on an entry that is not free");

  a_fit_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && fit_found) |=> fit_found)
    else $error("best fit lost during the scan");

endmodule

### hw/rtl/bfp_mul.sv
`timescale 1ns / 1ps

module bfp_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bfp_pkg::PAIR_BITS-1:0] a,
  input  logic [bfp_pkg::PAIR_BITS-1:0] b,
  output logic [bfp_pkg::AREA_BITS-1:0] p
);
  import bfp_pkg::*;

  logic [AREA_BITS-1:0] prod;

  assign prod = a * b;

  // hold the product until the sequencer issues the next pass
  always_ff @(posedge clk) begin
    if (en) p <= prod;
  end

endmodule

### hw/rtl/bfp_pool.sv
`timescale 1ns / 1ps

module bfp_pool (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bfp_pkg::IDX_BITS-1:0] rd_idx,
  output bfp_pkg::entry_rd_t           rd,
  input  bfp_pkg::pool_cmd_t           cmd
);
  import bfp_pkg::*;

  logic [NUM_BUFS-1:0]   valid;
  logic [NUM_BUFS-1:0]   busy;
  logic [KIND_BITS-1:0]  mem_kind  [NUM_BUFS];
  logic [KIND_BITS-1:0]  data_kind [NUM_BUFS];
  dims_t                 dims      [NUM_BUFS];
  logic [STAMP_BITS-1:0] stamp     [NUM_BUFS];
  logic [CNT_BITS-1:0]   free_cnt;
  logic                  taking;

  assign taking = (cmd.op == PC_TAKE) || (cmd.op == PC_EXPAND);

  always_comb begin
    rd.valid     = valid[rd_idx];
    rd.busy      = busy[rd_idx];
    rd.mem_kind  = mem_kind[rd_idx];
    rd.data_kind = data_kind[rd_idx];
    rd.dims      = dims[rd_idx];
    rd.stamp     = stamp[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      busy     <= '0;
      free_cnt <= '0;
    end else begin
      case (cmd.op)
        PC_RELEASE: begin
          busy[cmd.idx] <= 1'b0;
          free_cnt      <= free_cnt + 1'b1;
        end
        PC_TAKE, PC_EXPAND: begin
          busy[cmd.idx] <= 1'b1;
          if (free_cnt != '0) free_cnt <= free_cnt - 1'b1;
        end
        PC_CREATE: begin
          valid[cmd.idx] <= 1'b1;
          busy[cmd.idx]  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // entry payload and release order
  always_ff @(posedge clk) begin
    if (!rst) begin
      if (taking) begin
        // close the gap left in the release order
        for (int i = 0; i < NUM_BUFS; i++) begin
          if (valid[i] && !busy[i] && IDX_BITS'(i) != cmd.idx &&
              stamp[i] > stamp[cmd.idx]) begin
            stamp[i] <= stamp[i] - 1'b1;
          end
        end
        stamp[cmd.idx] <= '0;
      end
      case (cmd.op)
        PC_RELEASE: stamp[cmd.idx] <= free_cnt[STAMP_BITS-1:0];
        PC_EXPAND:  dims[cmd.idx]  <= cmd.dims;
        PC_CREATE: begin
          mem_kind[cmd.idx]  <= cmd.mem_kind;
          data_kind[cmd.idx] <= cmd.data_kind;
          dims[cmd.idx]      <= cmd.dims;
          stamp[cmd.idx]     <= '0;
        end
        default: ;
      endcase
    end
  end

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    int'(free_cnt) == $countones(valid & ~busy))
    else $error("free count out of step with entry flags");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == PC_TAKE || cmd.op == PC_EXPAND) |-> valid[cmd.idx] && !busy[cmd.idx])
    else $error("reuse of an entry that is not free");

  a_create_unused: assert property (@(posedge clk) disable iff (rst)
    cmd.op == PC_CREATE |-> !valid[cmd.idx])
    else $error("create over an entry in use");

endmodule
